// ===== src/ncas_pkg.sv =====
// Shared types and constants for the nixie cathode anti-poisoning sequencer.
`default_nettype none

package ncas_pkg;

	localparam int DIGITS = 4;
	localparam int DIG_W  = 4;
	localparam int CNT_W  = 4;

	localparam logic [DIG_W-1:0] TOP_DIGIT = 4'd9;
	localparam logic [CNT_W-1:0] ARM_AFTER = 4'd3;
	localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

	// Action codes of an input word
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	// What one lane sees of its digit for this tick
	typedef struct packed {
		logic [DIG_W-1:0] rolling;
		logic [DIG_W-1:0] target;
		logic [CNT_W-1:0] count;
		logic             armed;      // armed after earlier lanes of this tick
		logic             next_armed; // next digit's armed bit before this lane
		logic             is_last;
	} lane_in_t;

	// What one lane found
	typedef struct packed {
		logic             rolled;
		logic             finish;
		logic             kill;       // finished with next digit unarmed
		logic             arm_next;
		logic [DIG_W-1:0] nxt_rolling;
		logic [CNT_W-1:0] nxt_count;
		logic [DIG_W-1:0] shown;
	} lane_out_t;

	// Combined outcome of all lanes
	typedef struct packed {
		logic [DIGITS-1:0] armed_nxt;
		logic              running_nxt;
		logic [DIGITS-1:0] mask;
	} merge_t;

endpackage

`default_nettype wire

// ===== src/ncas_lane.sv =====
// One digit lane: roll-down step, target hit and cascade arming.
`default_nettype none

module ncas_lane import ncas_pkg::*; (
	input  lane_in_t  lane_in,
	output lane_out_t lane_out
);

	logic [DIG_W-1:0] dec;
	logic [CNT_W-1:0] cnt_inc;
	logic             hit;

	// Count down with wrap to nine, then decide roll or finish
	always_comb begin
		dec = lane_in.rolling - DIG_W'(1);
		if (dec > TOP_DIGIT) begin
			dec = TOP_DIGIT;
		end
		hit     = (dec == lane_in.target);
		cnt_inc = (lane_in.count == COUNT_MAX) ? lane_in.count : lane_in.count + CNT_W'(1);

		lane_out.rolled   = lane_in.armed & ~hit;
		lane_out.finish   = lane_in.armed & hit;
		lane_out.kill     = lane_out.finish & ~lane_in.is_last & ~lane_in.next_armed;
		lane_out.arm_next = lane_out.rolled & (cnt_inc > ARM_AFTER) & ~lane_in.is_last;

		lane_out.nxt_rolling = lane_in.armed ? dec : lane_in.rolling;
		if (lane_out.finish) begin
			lane_out.nxt_count = '0;
		end else if (lane_out.rolled) begin
			lane_out.nxt_count = cnt_inc;
		end else begin
			lane_out.nxt_count = lane_in.count;
		end
		lane_out.shown = lane_out.rolled ? dec : lane_in.target;
	end

endmodule

`default_nettype wire

// ===== src/ncas_merge.sv =====
// Merge stage: combine lane outcomes into armed bits, running flag and brightness mask.
`default_nettype none

module ncas_merge import ncas_pkg::*; (
	input  lane_out_t         lanes [DIGITS],
	input  logic [DIGITS-1:0] armed_eff,
	output merge_t            merged
);

	logic [DIGITS-1:0] finish_v;
	logic [DIGITS-1:0] rolled_v;
	logic              kill_any;

	// Gather per-lane flags
	always_comb begin
		finish_v = '0;
		rolled_v = '0;
		kill_any = 1'b0;
		for (int k = 0; k < DIGITS; k++) begin
			finish_v[k] = lanes[k].finish;
			rolled_v[k] = lanes[k].rolled;
			kill_any    = kill_any | lanes[k].kill;
		end
	end

	// Drop every armed bit on a broken cascade, else drop finished digits only
	always_comb begin
		merged.armed_nxt   = kill_any ? '0 : (armed_eff & ~finish_v);
		merged.running_nxt = ~kill_any & ~finish_v[DIGITS-1];
		merged.mask        = rolled_v;
	end

endmodule

`default_nettype wire

// ===== src/nixie_cathode_antipoison_sequencer_top.sv =====
// Top level of the nixie cathode anti-poisoning sequencer.
// A running tick word gives its result word in the cycle after it is accepted.
// Throughput: one input word per cycle while the input is not stalled; the four digit lanes work in the same cycle.
// Input stalls only while a result word waits and the output side stalls.
// Reset clears digits, targets, armed bits, step counts, running and the output valid.
`default_nettype none

module nixie_cathode_antipoison_sequencer_top import ncas_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             action,
	input  wire logic [DIG_W-1:0] from_digit_0,
	input  wire logic [DIG_W-1:0] from_digit_1,
	input  wire logic [DIG_W-1:0] from_digit_2,
	input  wire logic [DIG_W-1:0] from_digit_3,
	input  wire logic [DIG_W-1:0] to_digit_0,
	input  wire logic [DIG_W-1:0] to_digit_1,
	input  wire logic [DIG_W-1:0] to_digit_2,
	input  wire logic [DIG_W-1:0] to_digit_3,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [DIG_W-1:0]      shown_digit_0,
	output logic [DIG_W-1:0]      shown_digit_1,
	output logic [DIG_W-1:0]      shown_digit_2,
	output logic [DIG_W-1:0]      shown_digit_3,
	output logic [DIGITS-1:0]     bright_mask,
	output logic                  still_running
);

	logic [DIG_W-1:0]  from_w [DIGITS];
	logic [DIG_W-1:0]  to_w [DIGITS];

	logic [DIG_W-1:0]  rolling_q [DIGITS];
	logic [DIG_W-1:0]  target_q [DIGITS];
	logic [CNT_W-1:0]  count_q [DIGITS];
	logic [DIGITS-1:0] armed_q;
	logic              running_q;

	logic              out_valid_q;
	logic [DIG_W-1:0]  shown_q [DIGITS];
	logic [DIGITS-1:0] mask_q;
	logic              still_q;

	lane_in_t          lane_in [DIGITS];
	lane_out_t         lane_out [DIGITS];
	logic [DIGITS-1:0] armed_eff;
	logic [DIGITS-1:0] kill_pre;
	merge_t            merged;

	logic              in_acc;
	logic              do_start;
	logic              do_tick;

	assign from_w[0] = from_digit_0;
	assign from_w[1] = from_digit_1;
	assign from_w[2] = from_digit_2;
	assign from_w[3] = from_digit_3;
	assign to_w[0]   = to_digit_0;
	assign to_w[1]   = to_digit_1;
	assign to_w[2]   = to_digit_2;
	assign to_w[3]   = to_digit_3;

	// Hold the input while a result word waits on a stalled output
	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;
	assign do_start = in_acc & (action == ACT_START);
	assign do_tick  = in_acc & (action == ACT_TICK) & running_q;

	// Digit lanes, cascaded through the armed bits
	for (genvar k = 0; k < DIGITS; k++) begin : g_lane
		if (k == 0) begin : g_first
			assign kill_pre[k]  = 1'b0;
			assign armed_eff[k] = armed_q[k];
		end else begin : g_rest
			assign kill_pre[k]  = kill_pre[k-1] | lane_out[k-1].kill;
			assign armed_eff[k] = (armed_q[k] & ~kill_pre[k]) | lane_out[k-1].arm_next;
		end

		if (k == DIGITS - 1) begin : g_last
			assign lane_in[k].next_armed = 1'b0;
			assign lane_in[k].is_last    = 1'b1;
		end else begin : g_mid
			assign lane_in[k].next_armed = armed_q[k+1];
			assign lane_in[k].is_last    = 1'b0;
		end

		assign lane_in[k].rolling = rolling_q[k];
		assign lane_in[k].target  = target_q[k];
		assign lane_in[k].count   = count_q[k];
		assign lane_in[k].armed   = armed_eff[k];

		ncas_lane u_lane (
			.lane_in  (lane_in[k]),
			.lane_out (lane_out[k])
		);
	end

	ncas_merge u_merge (
		.lanes     (lane_out),
		.armed_eff (armed_eff),
		.merged    (merged)
	);

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= '0;
			running_q <= 1'b0;
			for (int k = 0; k < DIGITS; k++) begin
				rolling_q[k] <= '0;
				target_q[k]  <= '0;
				count_q[k]   <= '0;
			end
		end else if (do_start) begin
			armed_q[0] <= 1'b1;
			running_q  <= 1'b1;
			for (int k = 0; k < DIGITS; k++) begin
				rolling_q[k] <= from_w[k];
				target_q[k]  <= to_w[k];
			end
		end else if (do_tick) begin
			armed_q   <= merged.armed_nxt;
			running_q <= merged.running_nxt;
			for (int k = 0; k < DIGITS; k++) begin
				rolling_q[k] <= lane_out[k].nxt_rolling;
				count_q[k]   <= lane_out[k].nxt_count;
			end
		end
	end

	// Output word valid: load on a running tick, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_tick) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (do_tick) begin
			mask_q  <= merged.mask;
			still_q <= merged.running_nxt;
			for (int k = 0; k < DIGITS; k++) begin
				shown_q[k] <= lane_out[k].shown;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign shown_digit_0 = shown_q[0];
	assign shown_digit_1 = shown_q[1];
	assign shown_digit_2 = shown_q[2];
	assign shown_digit_3 = shown_q[3];
	assign bright_mask   = mask_q;
	assign still_running = still_q;

	// A running tick always yields a result word next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action == ACT_TICK && running_q) |=> out_valid)
		else $error("running tick gave no result word");

	// An idle tick or a start leaves no result word behind
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (action == ACT_START || !running_q)) |=> !out_valid)
		else $error("result word without a running tick");

	// A waiting result word reports the current running flag
	a_still_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (still_running == running_q))
		else $error("still_running disagrees with sequencer state");

endmodule

`default_nettype wire
